[rtl/pip_pkg.sv]
// Shared constants and types for the point-in-polygon test block.
`timescale 1ns / 1ps

package pip_pkg;

  // Default table depth and coordinate width
  localparam int PIP_MAX_VERTICES = 8;
  localparam int PIP_COORD_WIDTH  = 11;

  // Fixed field widths of the item format
  localparam int PIP_IDX_FIELD_W = 3;
  localparam int PIP_CNT_FIELD_W = 4;
  localparam int PIP_OUT_DATA_W  = 8;

  // Item kinds carried on in_tuser
  localparam logic PIP_MODE_WRITE = 1'b0;
  localparam logic PIP_MODE_TEST  = 1'b1;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LAST,
    S_LD_LAST,
    S_EDGE,
    S_WAIT,
    S_NEXT,
    S_DONE
  } pip_state_t;

  // Intercept unit states
  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } pip_unit_state_t;

endpackage

[rtl/point_in_polygon_test.sv]
// Top level: vertex table, edge sequencer and result register of the point-in-polygon test.
// Vertex write item: taken in S_IDLE, no result.
// Test item: each edge that straddles the test y starts the bit-serial divider in the intercept unit.
// One item is in work at a time; the next item is taken while the result waits in its register.
// Reset (synchronous, active low) clears the sequencer and the result valid; the table is not cleared.
`timescale 1ns / 1ps

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES,
  parameter int COORD_WIDTH  = PIP_COORD_WIDTH,
  localparam int IN_DATA_W   =
    ((PIP_IDX_FIELD_W + 2 * COORD_WIDTH + PIP_CNT_FIELD_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // vertex_index, coord_x, coord_y, vertex_count (lowest bits first), zero pad
  input  logic [IN_DATA_W-1:0]      in_tdata,
  // mode
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // inside_res, zero pad
  output logic [PIP_OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int CCMP_W  = (CNT_W > PIP_CNT_FIELD_W) ? CNT_W : PIP_CNT_FIELD_W;
  localparam int ICMP_W  = (CNT_W > PIP_IDX_FIELD_W) ? CNT_W : PIP_IDX_FIELD_W;
  localparam int X_LO    = PIP_IDX_FIELD_W;
  localparam int Y_LO    = X_LO + COORD_WIDTH;
  localparam int C_LO    = Y_LO + COORD_WIDTH;
  localparam int ENTRY_W = 2 * COORD_WIDTH;

  // Input fields
  logic [PIP_IDX_FIELD_W-1:0] f_index;
  logic [COORD_WIDTH-1:0]     f_x;
  logic [COORD_WIDTH-1:0]     f_y;
  logic [PIP_CNT_FIELD_W-1:0] f_count;

  assign f_index = in_tdata[PIP_IDX_FIELD_W-1:0];
  assign f_x     = in_tdata[Y_LO-1:X_LO];
  assign f_y     = in_tdata[C_LO-1:Y_LO];
  assign f_count = in_tdata[C_LO+PIP_CNT_FIELD_W-1:C_LO];

  pip_state_t state_r, state_nxt;

  logic [COORD_WIDTH-1:0] tx_r, tx_nxt;
  logic [COORD_WIDTH-1:0] ty_r, ty_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [COORD_WIDTH-1:0] prev_x_r, prev_x_nxt;
  logic [COORD_WIDTH-1:0] prev_y_r, prev_y_nxt;
  logic [COORD_WIDTH-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_WIDTH-1:0] cur_y_r, cur_y_nxt;
  logic                   inside_r, inside_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_inside_r, out_inside_nxt;

  // Table and intercept unit hookup
  logic                   ram_we;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [COORD_WIDTH-1:0] rd_x;
  logic [COORD_WIDTH-1:0] rd_y;
  logic                   unit_start;
  logic                   unit_done;
  logic signed [COORD_WIDTH:0]   unit_dx;
  logic signed [COORD_WIDTH:0]   unit_dn;
  logic signed [COORD_WIDTH:0]   unit_dd;
  logic signed [COORD_WIDTH:0]   unit_quot;
  logic signed [COORD_WIDTH+1:0] icept;
  logic                   left_of;
  logic                   straddle;
  logic                   wr_ok;
  logic [CCMP_W-1:0]      count_ext;
  logic [CNT_W-1:0]       count_sat;
  logic [CNT_W-1:0]       cnt_last;
  logic                   take;

  // Saturate count and range-check the write slot
  assign count_ext = CCMP_W'(f_count);
  assign count_sat = (count_ext > CCMP_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                         : CNT_W'(count_ext);
  assign wr_ok     = ICMP_W'(f_index) < ICMP_W'(MAX_VERTICES);
  assign take      = in_tvalid && in_tready;
  assign ram_we    = take && (in_tuser == PIP_MODE_WRITE) && wr_ok;
  assign cnt_last  = cnt_r - 1'b1;

  pip_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(f_index)),
    .wdata ({f_y, f_x}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[COORD_WIDTH-1:0];
  assign rd_y = ram_rdata[ENTRY_W-1:COORD_WIDTH];

  // Edge operands from previous vertex and the vertex just read
  assign straddle = (rd_y > ty_r) != (prev_y_r > ty_r);
  assign unit_dx  = $signed({1'b0, prev_x_r}) - $signed({1'b0, rd_x});
  assign unit_dn  = $signed({1'b0, ty_r}) - $signed({1'b0, rd_y});
  assign unit_dd  = $signed({1'b0, prev_y_r}) - $signed({1'b0, rd_y});

  pip_icept #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_icept (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .dx    (unit_dx),
    .dn    (unit_dn),
    .dd    (unit_dd),
    .done  (unit_done),
    .quot  (unit_quot)
  );

  assign icept   = (COORD_WIDTH+2)'(unit_quot) + $signed({2'b00, cur_x_r});
  assign left_of = $signed({2'b00, tx_r}) < icept;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tx_r         <= tx_nxt;
    ty_r         <= ty_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    inside_r     <= inside_nxt;
    out_inside_r <= out_inside_nxt;
  end

  // Sequencer over the polygon edges
  always_comb begin
    state_nxt      = state_r;
    tx_nxt         = tx_r;
    ty_nxt         = ty_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    inside_nxt     = inside_r;
    out_inside_nxt = out_inside_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    in_tready      = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;
    unit_start     = 1'b0;
    unique case (state_r)
      // Take an item; writes finish here
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_tuser == PIP_MODE_TEST)) begin
          tx_nxt     = f_x;
          ty_nxt     = f_y;
          cnt_nxt    = count_sat;
          inside_nxt = 1'b0;
          state_nxt  = (count_sat == '0) ? S_DONE : S_RD_LAST;
        end
      end
      // Read the last vertex, which opens the first edge
      S_RD_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(cnt_last);
        state_nxt = S_LD_LAST;
      end
      S_LD_LAST: begin
        prev_x_nxt = rd_x;
        prev_y_nxt = rd_y;
        idx_nxt    = '0;
        ram_re     = 1'b1;
        ram_raddr  = '0;
        state_nxt  = S_EDGE;
      end
      // Test the edge; start the intercept when it straddles
      S_EDGE: begin
        cur_x_nxt = rd_x;
        cur_y_nxt = rd_y;
        if (straddle) begin
          unit_start = 1'b1;
          state_nxt  = S_WAIT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_WAIT: begin
        if (unit_done) begin
          if (left_of) begin
            inside_nxt = !inside_r;
          end
          state_nxt = S_NEXT;
        end
      end
      // Advance to the next vertex or finish
      S_NEXT: begin
        prev_x_nxt = cur_x_r;
        prev_y_nxt = cur_y_r;
        if (CNT_W'(idx_r) == cnt_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = idx_r + 1'b1;
          state_nxt = S_EDGE;
        end
      end
      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = inside_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(PIP_OUT_DATA_W-1){1'b0}}, out_inside_r};

endmodule

[rtl/pip_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pip_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pip_icept.sv]
// Shared intercept unit: one multiply, then a bit-serial signed truncating divide.
`timescale 1ns / 1ps

module pip_icept
  import pip_pkg::*;
#(
  parameter int COORD_WIDTH = PIP_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_WIDTH:0]   dx,
  input  logic signed [COORD_WIDTH:0]   dn,
  input  logic signed [COORD_WIDTH:0]   dd,
  output logic                          done,
  output logic signed [COORD_WIDTH:0]   quot
);

  localparam int NUM_W  = 2 * COORD_WIDTH;
  localparam int PROD_W = 2 * COORD_WIDTH + 2;
  localparam int BCNT_W = $clog2(NUM_W);

  pip_unit_state_t state_r, state_nxt;

  logic signed [COORD_WIDTH:0] dx_r, dx_nxt;
  logic signed [COORD_WIDTH:0] dn_r, dn_nxt;
  logic signed [COORD_WIDTH:0] dd_r, dd_nxt;
  logic [NUM_W-1:0]            num_r, num_nxt;
  logic [COORD_WIDTH-1:0]      den_r, den_nxt;
  logic [COORD_WIDTH-1:0]      rem_r, rem_nxt;
  logic                        neg_r, neg_nxt;
  logic [BCNT_W-1:0]           bcnt_r, bcnt_nxt;
  logic                        done_r, done_nxt;

  logic signed [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]           prod_mag;
  logic [COORD_WIDTH:0]        dd_mag;
  logic [COORD_WIDTH:0]        shifted;
  logic [COORD_WIDTH:0]        trial;
  logic [COORD_WIDTH:0]        qmag;

  assign prod     = dx_r * dn_r;
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign dd_mag   = dd_r[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dd_r) : (COORD_WIDTH+1)'(dd_r);
  assign shifted  = {rem_r, num_r[NUM_W-1]};
  assign trial    = shifted - {1'b0, den_r};

  // Quotient magnitude never exceeds |dx|, so the low bits hold it
  assign qmag = {1'b0, num_r[COORD_WIDTH-1:0]};
  assign quot = neg_r ? $signed(-qmag) : $signed(qmag);
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dn_r   <= dn_nxt;
    dd_r   <= dd_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    bcnt_r <= bcnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    dx_nxt    = dx_r;
    dn_nxt    = dn_r;
    dd_nxt    = dd_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    bcnt_nxt  = bcnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      // Capture operands
      U_IDLE: begin
        if (start) begin
          dx_nxt    = dx;
          dn_nxt    = dn;
          dd_nxt    = dd;
          state_nxt = U_MUL;
        end
      end
      // Multiply and split into sign and magnitudes
      U_MUL: begin
        num_nxt   = prod_mag[NUM_W-1:0];
        den_nxt   = dd_mag[COORD_WIDTH-1:0];
        neg_nxt   = (prod != '0) && (prod[PROD_W-1] ^ dd_r[COORD_WIDTH]);
        rem_nxt   = '0;
        bcnt_nxt  = '0;
        state_nxt = U_DIV;
      end
      // One restoring divide step per cycle
      U_DIV: begin
        if (!trial[COORD_WIDTH]) begin
          rem_nxt = trial[COORD_WIDTH-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[COORD_WIDTH-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == BCNT_W'(NUM_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

endmodule

[rtl/pip_checker.sv]
// Port-level checker for the point-in-polygon test block, bound to the top level.
`timescale 1ns / 1ps

module pip_checker
  import pip_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [PIP_OUT_DATA_W-1:0] out_tdata
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A vertex write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == PIP_MODE_WRITE) && !out_tvalid |=> !out_tvalid)
    else $error("result after a vertex write");

  // A test occupies the block
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == PIP_MODE_TEST) |=> !in_tready)
    else $error("ready right after a test item");

  // Only the result bit may be set
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PIP_OUT_DATA_W-1:1] == '0))
    else $error("nonzero pad bits in result");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[bench/tb.sv]
// Self-checking testbench for the point-in-polygon test block.
`timescale 1ns / 1ps

module tb;
  import pip_pkg::*;

  localparam int CW        = PIP_COORD_WIDTH;
  localparam int COORD_MAX = (1 << CW) - 1;
  localparam int DATA_W    = ((PIP_IDX_FIELD_W + 2 * CW + PIP_CNT_FIELD_W + 7) / 8) * 8;
  localparam int PAD_W     = DATA_W - (PIP_IDX_FIELD_W + 2 * CW + PIP_CNT_FIELD_W);
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 5000;

  typedef logic [CW-1:0]              coord_t;
  typedef logic [PIP_IDX_FIELD_W-1:0] slot_t;
  typedef logic [PIP_CNT_FIELD_W-1:0] count_t;

  // Vertex table copy, crossing-number predictor and queue of expected flags
  class inside_scoreboard;
    coord_t vert_x[PIP_MAX_VERTICES];
    coord_t vert_y[PIP_MAX_VERTICES];
    bit     inside_expected[$];
    int     mismatches;
    int     writes_seen;
    int     tests_seen;
    int     inside_seen;

    function bit crossing_parity(int unsigned cnt, longint tx, longint ty);
      longint xi, yi, xj, yj, icept;
      int unsigned prev;
      bit parity;
      parity = 1'b0;
      if (cnt == 0) return 1'b0;
      prev = cnt - 1;
      for (int unsigned cur = 0; cur < cnt; cur++) begin
        xi = longint'(vert_x[cur]);
        yi = longint'(vert_y[cur]);
        xj = longint'(vert_x[prev]);
        yj = longint'(vert_y[prev]);
        // Edge straddles the test y: compare against the truncated intercept
        if ((yi > ty) != (yj > ty)) begin
          icept = (xj - xi) * (ty - yi) / (yj - yi) + xi;
          if (tx < icept) parity = ~parity;
        end
        prev = cur;
      end
      return parity;
    endfunction

    function void note_item(logic mode, slot_t slot, coord_t x, coord_t y, count_t cnt);
      int unsigned used;
      if (mode == PIP_MODE_WRITE) begin
        if (slot < PIP_MAX_VERTICES) begin
          vert_x[slot] = x;
          vert_y[slot] = y;
        end
        writes_seen++;
      end else begin
        used = (cnt > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : cnt;
        inside_expected.push_back(crossing_parity(used, longint'(x), longint'(y)));
        tests_seen++;
      end
    endfunction

    function void check_inside(logic [PIP_OUT_DATA_W-1:0] data);
      bit want;
      if (inside_expected.size() == 0) begin
        $error("result item with no test pending: out_tdata=%0h", data);
        mismatches++;
        return;
      end
      want = inside_expected.pop_front();
      if (want) inside_seen++;
      if (data[0] !== want) begin
        $error("inside_res: expected %0d, got %0d", want, data[0]);
        mismatches++;
      end
      if (data[PIP_OUT_DATA_W-1:1] !== '0) begin
        $error("out_pad: expected 0, got %0h", data[PIP_OUT_DATA_W-1:1]);
        mismatches++;
      end
    endfunction

    function int pending();
      return inside_expected.size();
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata   = '0;
  logic               in_tuser   = PIP_MODE_WRITE;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [PIP_OUT_DATA_W-1:0] out_tdata;

  int send_idle_pct = 29;
  int recv_idle_pct = 55;
  int stall_cycles  = 0;

  inside_scoreboard sb = new();

  point_in_polygon_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Record accepted items; check results before noting new input
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_inside(out_tdata);
      if (in_tvalid && in_tready) begin
        sb.note_item(in_tuser, in_tdata[2:0], in_tdata[3 +: CW], in_tdata[3 + CW +: CW],
                     in_tdata[3 + 2 * CW +: PIP_CNT_FIELD_W]);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("point_in_polygon_test verification failed");
      $finish;
    end
  end

  // Drive one item after a random gap and hold it until accepted
  task automatic send_item(logic mode, slot_t slot, coord_t x, coord_t y, count_t cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{PAD_W{1'b0}}, cnt, y, x, slot};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_vertex(slot_t slot, coord_t x, coord_t y);
    send_item(PIP_MODE_WRITE, slot, x, y, count_t'($urandom_range(0, 15)));
  endtask

  task automatic test_point(coord_t x, coord_t y, count_t cnt);
    send_item(PIP_MODE_TEST, slot_t'($urandom_range(0, 7)), x, y, cnt);
  endtask

  // Random test point: anywhere, on a vertex row, or near a vertex
  task automatic random_test();
    count_t cnt;
    int     pick, slot, px, py;
    cnt  = ($urandom_range(0, 9) < 7) ? count_t'($urandom_range(3, 8))
                                      : count_t'($urandom_range(0, 15));
    pick = $urandom_range(0, 2);
    slot = $urandom_range(0, PIP_MAX_VERTICES - 1);
    px   = $urandom_range(0, COORD_MAX);
    py   = $urandom_range(0, COORD_MAX);
    if (pick == 1) begin
      py = sb.vert_y[slot];
    end else if (pick == 2) begin
      px = int'(sb.vert_x[slot]) + $urandom_range(0, 128) - 64;
      py = int'(sb.vert_y[slot]) + $urandom_range(0, 128) - 64;
      px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
      py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
    end
    test_point(coord_t'(px), coord_t'(py), cnt);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot first so no test reads an unwritten entry
    write_vertex(3'd0, '0, '0);
    write_vertex(3'd1, coord_t'(COORD_MAX), '0);
    write_vertex(3'd2, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    write_vertex(3'd3, '0, coord_t'(COORD_MAX));
    write_vertex(3'd4, 11'd1024, 11'd1024);
    write_vertex(3'd5, 11'd512, 11'd1536);
    write_vertex(3'd6, 11'd1536, 11'd512);
    write_vertex(3'd7, 11'd1023, 11'd1023);

    // Directed tests: empty polygon, corners, horizontal edges, count limits
    test_point(11'd1000, 11'd1000, 4'd0);
    test_point(11'd1000, 11'd1000, 4'd4);
    test_point('0, '0, 4'd4);
    test_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 4'd4);
    test_point(11'd1000, '0, 4'd4);
    test_point(11'd1000, coord_t'(COORD_MAX), 4'd4);
    test_point('0, 11'd1000, 4'd4);
    test_point(11'd5, 11'd5, 4'd1);
    test_point(11'd5, 11'd5, 4'd2);
    test_point(11'd1024, 11'd900, 4'd8);
    test_point(11'd700, 11'd1300, 4'd9);
    test_point(11'd700, 11'd1300, 4'd15);
    test_point(11'd1500, 11'd512, 4'd8);
    // Degenerate thin polygon
    write_vertex(3'd2, 11'd2046, 11'd1);
    test_point(11'd1000, '0, 4'd3);
    test_point('0, 11'd1, 4'd3);

    // Random phase: writes mixed into tests, mostly with counts of 3 to 8; idling rotates by thirds
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 29;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < 35) begin
        write_vertex(slot_t'($urandom_range(0, 7)), coord_t'($urandom_range(0, COORD_MAX)),
                     coord_t'($urandom_range(0, COORD_MAX)));
      end else begin
        random_test();
      end
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d vertex writes and %0d point tests, %0d of them inside.",
             sb.writes_seen, sb.tests_seen, sb.inside_seen);
    $display("Mismatches found: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("point_in_polygon_test verification clean");
    end else begin
      $display("point_in_polygon_test verification failed");
    end
    $finish;
  end

endmodule
